>>> rtl/bphrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphrt_pkg
// Shared types and constants of the button press/hold/release tracker.
// ----------------------------------------------------------------------------
package bphrt_pkg;

   localparam int EVENT_BITS = 3;
   localparam int HOLD_BITS  = 32;

   localparam logic [HOLD_BITS-1:0] HOLD_RESET = 32'd1000;

   typedef enum logic [EVENT_BITS-1:0] {
      PH_IDLE     = 3'd0,
      PH_PRESSED  = 3'd1,
      PH_TIMING   = 3'd2,
      PH_HOLD     = 3'd3,
      PH_RELEASED = 3'd4
   } phase_type;

   // register update controls from the step logic
   typedef struct packed {
      phase_type next_phase;
      logic      take_key;
      logic      take_start;
      logic      retire_key;
   } step_ctl_type;

endpackage

>>> rtl/bphrt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphrt_if
// Handshake channels of the tracker: sample input, result output, and the
// hold threshold write port.
// ----------------------------------------------------------------------------
interface bphrt_req_if #(
   parameter int KEY_BITS  = 8,
   parameter int TICK_BITS = 32
);
   logic                 valid;
   logic                 ready;
   logic [KEY_BITS-1:0]  key_mask;
   logic [TICK_BITS-1:0] now_tick;

   modport source (output valid, output key_mask, output now_tick, input ready);
   modport sink   (input valid, input key_mask, input now_tick, output ready);
endinterface

interface bphrt_rsp_if #(
   parameter int KEY_BITS = 8
);
   logic                                valid;
   logic                                ready;
   logic [bphrt_pkg::EVENT_BITS-1:0]    event_code;
   logic [KEY_BITS-1:0]                 current_key;
   logic [KEY_BITS-1:0]                 last_key;

   modport source (output valid, output event_code, output current_key,
                   output last_key, input ready);
   modport sink   (input valid, input event_code, input current_key,
                   input last_key, output ready);
endinterface

interface bphrt_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bphrt_pkg::HOLD_BITS-1:0]  hold_ticks;

   modport source (output valid, output hold_ticks, input ready);
   modport sink   (input valid, input hold_ticks, output ready);
endinterface

>>> rtl/bphrt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphrt_step
// Next-phase decision for one key sample, including the wrap-around
// elapsed-time compare against the hold threshold.
// ----------------------------------------------------------------------------
module bphrt_step #(
   parameter int KEY_BITS  = 8,
   parameter int TICK_BITS = 32
) (
   input  bphrt_pkg::phase_type          phase,
   input  logic [KEY_BITS-1:0]           key_mask,
   input  logic [TICK_BITS-1:0]          now_tick,
   input  logic [KEY_BITS-1:0]           tracked_key,
   input  logic [TICK_BITS-1:0]          start_tick,
   input  logic [bphrt_pkg::HOLD_BITS-1:0] hold_ticks,
   output bphrt_pkg::step_ctl_type       ctl
);

   localparam int CMP_BITS = (TICK_BITS > bphrt_pkg::HOLD_BITS) ?
                             TICK_BITS : bphrt_pkg::HOLD_BITS;

   logic [TICK_BITS-1:0] elapsed;
   logic                 held_long;
   logic                 no_key;
   logic                 same_key;

   // subtraction wraps modulo 2^TICK_BITS
   assign elapsed   = now_tick - start_tick;
   assign held_long = CMP_BITS'(elapsed) > CMP_BITS'(hold_ticks);
   assign no_key    = (key_mask == '0);
   assign same_key  = (key_mask == tracked_key);

   always_comb begin
      ctl.next_phase = phase;
      ctl.take_key   = 1'b0;
      ctl.take_start = 1'b0;
      ctl.retire_key = 1'b0;
      case (phase)
         bphrt_pkg::PH_IDLE: begin
            if (!no_key) begin
               ctl.take_key   = 1'b1;
               ctl.next_phase = bphrt_pkg::PH_PRESSED;
            end
         end
         bphrt_pkg::PH_PRESSED: begin
            if (no_key) begin
               ctl.next_phase = bphrt_pkg::PH_RELEASED;
            end else if (same_key) begin
               ctl.next_phase = bphrt_pkg::PH_TIMING;
               ctl.take_start = 1'b1;
            end else begin
               ctl.take_key = 1'b1;
            end
         end
         bphrt_pkg::PH_TIMING: begin
            if (no_key) begin
               ctl.next_phase = bphrt_pkg::PH_RELEASED;
            end else if (same_key) begin
               if (held_long) begin
                  ctl.next_phase = bphrt_pkg::PH_HOLD;
               end
            end else begin
               ctl.take_key   = 1'b1;
               ctl.next_phase = bphrt_pkg::PH_PRESSED;
            end
         end
         bphrt_pkg::PH_HOLD: begin
            if (no_key) begin
               ctl.next_phase = bphrt_pkg::PH_RELEASED;
            end else if (!same_key) begin
               ctl.take_key   = 1'b1;
               ctl.next_phase = bphrt_pkg::PH_PRESSED;
            end
         end
         bphrt_pkg::PH_RELEASED: begin
            // sample ignored; key moves to last-key
            ctl.retire_key = 1'b1;
            ctl.next_phase = bphrt_pkg::PH_IDLE;
         end
         default: begin
            ctl.next_phase = phase;
         end
      endcase
   end

endmodule

>>> rtl/button_press_hold_release_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_hold_release_tracker_core
// Tracks press, timing, hold and release of a sampled key mask.
// Path: the input register captures the sample beat, then the result register
// takes the result of the phase update.
// Throughput: one sample beat per cycle while the result is taken; the input
// register lets a new sample in while a finished result waits.
// Reset: phase idle, keys and start tick zero, hold_ticks 1000.
// ----------------------------------------------------------------------------
module button_press_hold_release_tracker_core #(
   parameter int KEY_BITS  = 8,
   parameter int TICK_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   bphrt_req_if.sink    req_ch,
   bphrt_rsp_if.source  rsp_ch,
   bphrt_csr_if.sink    csr_ch
);

   // input stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [KEY_BITS-1:0]  s1_key_ff;
   logic [TICK_BITS-1:0] s1_tick_ff;

   // tracker state
   bphrt_pkg::phase_type            phase_ff, phase_in;
   logic [KEY_BITS-1:0]             tracked_key_ff, tracked_key_in;
   logic [KEY_BITS-1:0]             released_key_ff, released_key_in;
   logic [TICK_BITS-1:0]            start_tick_ff, start_tick_in;
   logic [bphrt_pkg::HOLD_BITS-1:0] hold_ticks_ff, hold_ticks_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [bphrt_pkg::EVENT_BITS-1:0] rsp_event_ff;
   logic [KEY_BITS-1:0]              rsp_current_ff;
   logic [KEY_BITS-1:0]              rsp_last_ff;

   bphrt_pkg::step_ctl_type ctl;

   logic req_go;
   logic s1_go;
   logic rsp_free;

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_go        = s1_valid_ff && rsp_free;
   assign req_ch.ready = !s1_valid_ff || rsp_free;
   assign req_go       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   bphrt_step #(
      .KEY_BITS  (KEY_BITS),
      .TICK_BITS (TICK_BITS)
   ) u_step (
      .phase       (phase_ff),
      .key_mask    (s1_key_ff),
      .now_tick    (s1_tick_ff),
      .tracked_key (tracked_key_ff),
      .start_tick  (start_tick_ff),
      .hold_ticks  (hold_ticks_ff),
      .ctl         (ctl)
   );

   always_comb begin
      s1_valid_in     = req_go || (s1_valid_ff && !s1_go);
      rsp_valid_in    = s1_go || (rsp_valid_ff && !rsp_ch.ready);
      phase_in        = phase_ff;
      tracked_key_in  = tracked_key_ff;
      released_key_in = released_key_ff;
      start_tick_in   = start_tick_ff;
      hold_ticks_in   = hold_ticks_ff;
      if (s1_go) begin
         phase_in = ctl.next_phase;
         if (ctl.retire_key) begin
            released_key_in = tracked_key_ff;
            tracked_key_in  = '0;
         end else if (ctl.take_key) begin
            tracked_key_in = s1_key_ff;
         end
         if (ctl.take_start) begin
            start_tick_in = s1_tick_ff;
         end
      end
      if (csr_ch.valid) begin
         hold_ticks_in = csr_ch.hold_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= bphrt_pkg::PH_IDLE;
         tracked_key_ff  <= '0;
         released_key_ff <= '0;
         start_tick_ff   <= '0;
         hold_ticks_ff   <= bphrt_pkg::HOLD_RESET;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         phase_ff        <= phase_in;
         tracked_key_ff  <= tracked_key_in;
         released_key_ff <= released_key_in;
         start_tick_ff   <= start_tick_in;
         hold_ticks_ff   <= hold_ticks_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_go) begin
         s1_key_ff  <= req_ch.key_mask;
         s1_tick_ff <= req_ch.now_tick;
      end
      if (s1_go) begin
         rsp_event_ff   <= phase_in;
         rsp_current_ff <= tracked_key_in;
         rsp_last_ff    <= released_key_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.event_code  = rsp_event_ff;
   assign rsp_ch.current_key = rsp_current_ff;
   assign rsp_ch.last_key    = rsp_last_ff;

`ifndef SYNTH
   // a key is tracked exactly when the phase is not idle
   a_idle_key: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bphrt_pkg::PH_IDLE) == (tracked_key_ff == '0))
      else $error("tracked key does not match idle phase");

   // released always returns to idle on the next beat
   a_release_idle: assert property (@(posedge clock) disable iff (reset)
      (s1_go && phase_ff == bphrt_pkg::PH_RELEASED) |=> phase_ff == bphrt_pkg::PH_IDLE)
      else $error("released phase did not return to idle");

   // every processed beat lands in the result register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_valid_ff)
      else $error("processed beat lost");

   // phase and tracked key only move when a beat is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_go |=> $stable(phase_ff) && $stable(tracked_key_ff))
      else $error("state changed without a beat");
`endif

endmodule
